>>> src/cfos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfos_pkg
// Shared types, constants and the exp2 mantissa table for the orbit stepper.
// ----------------------------------------------------------------------------
package cfos_pkg;

	localparam int WORD_W   = 32;
	localparam int FRAC_W   = 24;
	localparam int NTAB     = FRAC_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 200;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK   = 2'd0;
	localparam status_t STAT_SAT  = 2'd1;
	localparam status_t STAT_ZERO = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_DT     = 3'd0;
	localparam cfg_idx_t REG_EXP    = 3'd1;
	localparam cfg_idx_t REG_STR    = 3'd2;
	localparam cfg_idx_t REG_PX     = 3'd3;
	localparam cfg_idx_t REG_PY     = 3'd4;
	localparam cfg_idx_t REG_VX     = 3'd5;
	localparam cfg_idx_t REG_VY     = 3'd6;

	localparam logic [23:0] RST_DT  = 24'd167772;
	localparam logic [6:0]  RST_EXP = 7'd32;
	localparam logic [30:0] RST_STR = 31'd662337934;
	localparam logic [31:0] RST_PX  = 32'd16777216;
	localparam logic [31:0] RST_PY  = 32'd0;
	localparam logic [31:0] RST_VX  = 32'd0;
	localparam logic [31:0] RST_VY  = 32'd105414369;

	typedef logic [NTAB-1:0][31:0] exp_tab_t;

	// floor square root, evaluated at elaboration only
	function automatic logic [63:0] isqrt_c(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		logic [63:0] rem;
		res = '0;
		bt  = 64'd1 << 62;
		rem = v;
		for (int i = 0; i < 32; i++) begin
			if (bt > rem) bt = bt >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bt != 0) begin
				if (rem >= res + bt) begin
					rem = rem - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-j) in q2.30 by repeated square roots for j from 1; entry 0 holds 1.0
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [63:0] w;
		t[0] = 32'd1 << 30;
		w    = isqrt_c(64'd2 << 60);
		t[1] = w[31:0];
		for (int j = 2; j < NTAB; j++) begin
			w    = isqrt_c({t[j-1], 30'd0} & 64'hFFFF_FFFF_FFFF_FFFF);
			t[j] = w[31:0];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> src/central_force_orbit_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// central_force_orbit_step
// Euler-Cromer step of one body in an inverse-power central field, all
// multiplications on one shared 32x32 multiplier under a sequencer.
// ----------------------------------------------------------------------------
// the square root, the normalise shifts, 24 log2 squarings and 24 exp2 table
// steps (with a table multiply for each set bit) dominate the run time; a zero
// radius goes straight from the normaliser to the position update.
// the next item is taken only once the result is in the output register, so
// items do not overlap. reset restores the register defaults and the start
// state.
module central_force_orbit_step (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  cfos_pkg::cfg_idx_t      cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [cfos_pkg::IN_W-1:0] s_axis_tdata,  // reload
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// radius, vel_x, vel_y, pos_x, pos_y, step_index, status
	output logic [cfos_pkg::OUT_W-1:0] m_axis_tdata
);
	import cfos_pkg::*;

	localparam logic [63:0] LIM = 64'h2_0000_0000;

	typedef enum logic [4:0] {
		S_IDLE, S_SQX, S_SQY, S_SUM, S_SQRT, S_NORM, S_LOGM, S_LOGU,
		S_EXPM, S_EXPU, S_MANT, S_MANU, S_S1, S_S2, S_S3, S_S4, S_S5, S_S6,
		S_P1, S_P2, S_P3, S_DONE
	} state_t;

	state_t state_q;

	logic [23:0] dt_q;
	logic [6:0]  fexp_q;
	logic [30:0] str_q;
	logic [31:0] spx_q, spy_q, svx_q, svy_q;
	logic [31:0] px_q, py_q, vx_q, vy_q, step_q;

	logic [63:0] mul_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] acc_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic [31:0] z_q;
	logic [4:0]  p_q;
	logic [23:0] frac_q;
	logic [11:0] k_q;
	logic [23:0] f_q;
	logic [31:0] m_q;
	logic [31:0] c_q;
	logic [63:0] prx_q, pry_q;
	logic        sat_q, zero_q;
	logic        out_valid_q;
	logic [OUT_W-1:0] out_q;

	logic [31:0] ax, ay, avx, avy;
	logic [35:0] rem_sh, trial;
	logic [32:0] sq_t;
	logic [7:0]  log_int;
	logic [31:0] logv, alog;
	logic [63:0] eq;
	logic [32:0] vupd_x, vupd_y, pupd;
	logic [63:0] dsh;
	logic        s_acc;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [63:0] accel_f(input logic [63:0] prod, input logic [11:0] k);
		logic [12:0] sh;
		logic [12:0] n;
		logic [63:0] res;
		sh = {k[11], k} - 13'd24;
		n  = ~sh + 13'd1;
		if (prod == 64'd0) begin
			res = '0;
		end else if (!sh[12]) begin
			if (sh > 13'd33) res = LIM;
			else if (prod > (LIM >> sh[5:0])) res = LIM;
			else res = prod << sh[5:0];
		end else begin
			if (n >= 13'd64) res = '0;
			else res = prod >> n[5:0];
		end
		return res;
	endfunction

	// v - d when add is low, v + d when high; {sat, value}
	function automatic logic [32:0] upd_f(input logic [31:0] v, input logic add,
			input logic [63:0] d);
		logic signed [65:0] ve, de, diff;
		logic [32:0] res;
		ve   = {{34{v[31]}}, v};
		de   = {2'b00, d};
		diff = add ? ve + de : ve - de;
		if (diff > 66'sh0_0000_0000_7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
		else if (diff < -66'sh0_0000_0000_8000_0000) res = {1'b1, 32'h8000_0000};
		else res = {1'b0, diff[31:0]};
		return res;
	endfunction

	assign ax  = mag32(px_q);
	assign ay  = mag32(py_q);
	assign avx = mag32(vx_q);
	assign avy = mag32(vy_q);

	assign rem_sh  = {rem_q, acc_q[63:62]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign sq_t    = mul_q[63:31];
	// integer part of log2 is the msb position less the fraction width
	assign log_int = {3'b000, p_q} - 8'd24;
	assign logv    = {log_int, frac_q};
	assign alog    = logv[31] ? (~logv + 32'd1) : logv;
	assign eq      = logv[31] ? mul_q : (~mul_q + 64'd1);
	assign dsh     = accel_f((state_q == S_S5) ? prx_q : pry_q, k_q);
	assign vupd_x  = upd_f(vx_q, px_q[31], dsh);
	assign vupd_y  = upd_f(vy_q, py_q[31], dsh);
	assign pupd    = (state_q == S_P2) ? upd_f(px_q, !vx_q[31], {32'd0, mul_q[55:24]})
	                                   : upd_f(py_q, !vy_q[31], {32'd0, mul_q[55:24]});

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQX:  begin mul_a = ax;  mul_b = ax; end
			S_SQY:  begin mul_a = ay;  mul_b = ay; end
			S_LOGM: begin mul_a = z_q; mul_b = z_q; end
			S_EXPM: begin mul_a = alog; mul_b = {24'd0, 8'(fexp_q) + 8'd16}; end
			S_MANT: begin mul_a = m_q; mul_b = EXP_TAB[5'd24 - cnt_q]; end
			S_S1:   begin mul_a = {1'b0, str_q}; mul_b = m_q; end
			S_S2:   begin mul_a = mul_q[61:30]; mul_b = {8'd0, dt_q}; end
			S_S3:   begin mul_a = mul_q[55:24]; mul_b = ax; end
			S_S4:   begin mul_a = c_q; mul_b = ay; end
			S_P1:   begin mul_a = avx; mul_b = {8'd0, dt_q}; end
			S_P2:   begin mul_a = avy; mul_b = {8'd0, dt_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dt_q        <= RST_DT;
			fexp_q      <= RST_EXP;
			str_q       <= RST_STR;
			spx_q       <= RST_PX;
			spy_q       <= RST_PY;
			svx_q       <= RST_VX;
			svy_q       <= RST_VY;
			px_q        <= RST_PX;
			py_q        <= RST_PY;
			vx_q        <= RST_VX;
			vy_q        <= RST_VY;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
			zero_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DT:  dt_q   <= cfg_data[23:0];
					REG_EXP: fexp_q <= cfg_data[6:0];
					REG_STR: str_q  <= cfg_data[30:0];
					REG_PX:  spx_q  <= cfg_data;
					REG_PY:  spy_q  <= cfg_data;
					REG_VX:  svx_q  <= cfg_data;
					REG_VY:  svy_q  <= cfg_data;
					default: ;
				endcase
			end
			// the done state hands over the output register itself
			if (out_valid_q && m_axis_tready && state_q != S_DONE) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						if (s_axis_tdata[0]) begin
							px_q   <= spx_q;
							py_q   <= spy_q;
							vx_q   <= svx_q;
							vy_q   <= svy_q;
							step_q <= '0;
						end
						sat_q   <= 1'b0;
						zero_q  <= 1'b0;
						state_q <= S_SQX;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					acc_q   <= mul_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + mul_q;
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				// one result bit per cycle
				S_SQRT: begin
					if (rem_sh >= trial) begin
						rem_q  <= 34'(rem_sh - trial);
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q  <= rem_sh[33:0];
						root_q <= {root_q[30:0], 1'b0};
					end
					acc_q <= acc_q << 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= S_NORM;
				end
				S_NORM: begin
					if (root_q == 32'd0) begin
						zero_q  <= 1'b1;
						state_q <= S_P1;
					end else if (z_q[31]) begin
						cnt_q   <= '0;
						frac_q  <= '0;
						state_q <= S_LOGM;
					end else begin
						z_q <= z_q << 1;
						p_q <= p_q - 5'd1;
					end
				end
				S_LOGM: state_q <= S_LOGU;
				S_LOGU: begin
					frac_q <= {frac_q[22:0], sq_t[32]};
					z_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
					cnt_q  <= cnt_q + 5'd1;
					state_q <= (cnt_q == 5'd23) ? S_EXPM : S_LOGM;
				end
				S_EXPM: state_q <= S_EXPU;
				S_EXPU: begin
					k_q     <= eq[39:28];
					f_q     <= eq[27:4];
					m_q     <= 32'd1 << 30;
					cnt_q   <= 5'd23;
					state_q <= S_MANT;
				end
				// cnt counts down; table index is 24 - cnt
				S_MANT: begin
					if (f_q[23]) begin
						state_q <= S_MANU;
					end else begin
						f_q   <= f_q << 1;
						cnt_q <= cnt_q - 5'd1;
						if (cnt_q == 5'd0) state_q <= S_S1;
					end
				end
				S_MANU: begin
					m_q   <= mul_q[61:30];
					f_q   <= f_q << 1;
					cnt_q <= cnt_q - 5'd1;
					state_q <= (cnt_q == 5'd0) ? S_S1 : S_MANT;
				end
				S_S1: state_q <= S_S2;
				S_S2: state_q <= S_S3;
				S_S3: begin
					c_q     <= mul_q[55:24];
					state_q <= S_S4;
				end
				S_S4: begin
					prx_q   <= mul_q;
					state_q <= S_S5;
				end
				S_S5: begin
					pry_q   <= mul_q;
					vx_q    <= vupd_x[31:0];
					sat_q   <= sat_q | vupd_x[32];
					state_q <= S_S6;
				end
				S_S6: begin
					vy_q    <= vupd_y[31:0];
					sat_q   <= sat_q | vupd_y[32];
					state_q <= S_P1;
				end
				S_P1: state_q <= S_P2;
				S_P2: begin
					px_q    <= pupd[31:0];
					sat_q   <= sat_q | pupd[32];
					state_q <= S_P3;
				end
				S_P3: begin
					py_q    <= pupd[31:0];
					sat_q   <= sat_q | pupd[32];
					step_q  <= step_q + 32'd1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_q <= {6'd0,
							zero_q ? STAT_ZERO : (sat_q ? STAT_SAT : STAT_OK),
							step_q, py_q, px_q, vy_q, vx_q, root_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// normaliser seeds from the root as it completes
			if (state_q == S_SQRT && cnt_q == 5'd31) begin
				z_q <= (rem_sh >= trial) ? {root_q[30:0], 1'b1} : {root_q[30:0], 1'b0};
				p_q <= 5'd31;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("item accepted while a step is running");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[193:192] != 2'd3))
		else $error("undefined status code");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[31:0] == 32'd0) ==
			(m_axis_tdata[193:192] == STAT_ZERO)))
		else $error("zero radius and status disagree");

endmodule

>>> tb/central_force_orbit_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// central_force_orbit_step_tb
// Drives reload items into the orbit stepper over a walked table of directed
// cases and then randomised register phases. Every result is checked field by
// field against an in-bench fixed-point orbit predictor, with random idling
// on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module central_force_orbit_step_tb;
	import cfos_pkg::*;

	localparam cfg_idx_t REG_NONE = 3'd7;
	localparam int PHASES = 13;
	localparam int PHASE_ITEMS = 150;
	localparam int QUIET_PHASE = 11;
	localparam int LONG_HOLD = 800;

	typedef struct {
		logic [31:0] radius;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] step_index;
		status_t     status;
	} orbit_res_t;

	typedef struct {
		bit          is_cfg;
		cfg_idx_t    idx;
		logic [31:0] data;
		bit          reload;
		bit          typed;
		logic [31:0] t_radius;
		logic [31:0] t_step;
		status_t     t_status;
	} dir_row_t;

	localparam int NROWS = 39;
	dir_row_t script [NROWS] = '{
		'{0, REG_DT, 32'd0, 0, 1, 32'd16777216, 32'd1, STAT_OK},
		'{0, REG_DT, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 1, 1, 32'd16777216, 32'd1, STAT_OK},
		'{1, REG_PX, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_PY, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 1, 1, 32'd0, 32'd1, STAT_ZERO},
		'{0, REG_DT, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_PX, 32'h8000_0000, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_PY, 32'h8000_0000, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_VX, 32'h8000_0000, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_VY, 32'h7FFF_FFFF, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_DT, 32'hFFFF_FFFF, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_STR, 32'hFFFF_FFFF, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_EXP, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 1, 1, 32'd3037000499, 32'd1, STAT_SAT},
		'{0, REG_DT, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_EXP, 32'hFFFF_FFFF, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_DT, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_STR, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_PX, 32'h7FFF_FFFF, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_PY, 32'd1, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_VX, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_VY, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 1, 1, 32'd2147483647, 32'd1, STAT_OK},
		'{1, REG_NONE, 32'h1234_5678, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 0, 1, 32'd2147483647, 32'd2, STAT_OK},
		'{1, REG_DT, 32'd167772, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_STR, 32'd662337934, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_EXP, 32'd64, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_PX, 32'd1, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_PY, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 1, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_EXP, 32'd32, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_PX, 32'd16777216, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{1, REG_VY, 32'd105414369, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 1, 1, 32'd16777216, 32'd1, STAT_OK},
		'{0, REG_DT, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK},
		'{0, REG_DT, 32'd0, 0, 0, 32'd0, 32'd0, STAT_OK}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	cfg_idx_t           cfg_index;
	logic [31:0]        cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [OUT_W-1:0]   m_axis_tdata;

	central_force_orbit_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// predictor copy of registers and body state
	logic [23:0] reg_dt;
	logic [6:0]  reg_exp;
	logic [30:0] reg_str;
	longint      start_px, start_py, start_vx, start_vy;
	longint      body_px, body_py, body_vx, body_vy;
	logic [31:0] body_steps;
	logic [63:0] root_tab [FRAC_W+1];

	orbit_res_t  orbit_queue [$];
	int          fails;
	bit          quiet;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint log2_fix(logic [63:0] r);
		int p;
		logic [63:0] z, frac;
		p = 63;
		while (!r[p]) p--;
		z = (p <= 31) ? (r << (31 - p)) : (r >> (p - 31));
		frac = 0;
		for (int i = 0; i < FRAC_W; i++) begin
			z = (z * z) >> 31;
			frac = frac << 1;
			if (z >= (64'd1 << 32)) begin
				frac = frac | 64'd1;
				z = z >> 1;
			end
		end
		return (longint'(p) - FRAC_W) * 64'sd16777216 + longint'(frac);
	endfunction

	function automatic logic [63:0] pull_mag(logic [63:0] mant, int k, logic [63:0] apos);
		logic [63:0] lim, s, c, prod;
		int sh;
		lim = 64'd1 << 33;
		s = (64'(reg_str) * mant) >> 30;
		c = (s * 64'(reg_dt)) >> FRAC_W;
		prod = c * apos;
		sh = k - FRAC_W;
		if (prod == 0) return 0;
		if (sh >= 0) begin
			if (sh > 33 || prod > (lim >> sh)) return lim;
			return prod << sh;
		end
		if (-sh >= 64) return 0;
		return prod >> (-sh);
	endfunction

	function automatic logic [63:0] absval(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	function automatic bit outside32(longint v);
		return v > WMAX || v < WMIN;
	endfunction

	function automatic void set_reg(cfg_idx_t idx, logic [31:0] d);
		case (idx)
			REG_DT:  reg_dt = d[23:0];
			REG_EXP: reg_exp = d[6:0];
			REG_STR: reg_str = d[30:0];
			REG_PX:  start_px = longint'($signed(d));
			REG_PY:  start_py = longint'($signed(d));
			REG_VX:  start_vx = longint'($signed(d));
			REG_VY:  start_vy = longint'($signed(d));
			default: ;
		endcase
	endfunction

	function automatic orbit_res_t advance_orbit(bit reload);
		orbit_res_t res;
		logic [63:0] ax, ay, r, ub, f, m, dx, dy, mx, my;
		longint vx, vy, px, py, e, eq;
		int k;
		bit sat;
		status_t st;
		if (reload) begin
			body_px = start_px;
			body_py = start_py;
			body_vx = start_vx;
			body_vy = start_vy;
			body_steps = 0;
		end
		px = body_px; py = body_py; vx = body_vx; vy = body_vy;
		sat = 0;
		st = STAT_OK;
		ax = absval(px);
		ay = absval(py);
		r = floor_sqrt(ax * ax + ay * ay);
		if (r == 0) begin
			st = STAT_ZERO;
		end else begin
			e = longint'(reg_exp) + 16;
			eq = -(log2_fix(r) * e);
			ub = 64'(eq + (64'sd128 <<< 28));
			k = int'(ub >> 28) - 128;
			f = (ub >> 4) & 64'hFF_FFFF;
			m = 64'd1 << 30;
			for (int j = 1; j <= FRAC_W; j++)
				if (f[FRAC_W-j]) m = (m * root_tab[j]) >> 30;
			dx = pull_mag(m, k, ax);
			dy = pull_mag(m, k, ay);
			vx = vx - (px < 0 ? -longint'(dx) : longint'(dx));
			vy = vy - (py < 0 ? -longint'(dy) : longint'(dy));
			sat = sat | outside32(vx) | outside32(vy);
			vx = clamp32(vx);
			vy = clamp32(vy);
		end
		mx = (absval(vx) * 64'(reg_dt)) >> FRAC_W;
		my = (absval(vy) * 64'(reg_dt)) >> FRAC_W;
		px = px + (vx < 0 ? -longint'(mx) : longint'(mx));
		py = py + (vy < 0 ? -longint'(my) : longint'(my));
		sat = sat | outside32(px) | outside32(py);
		px = clamp32(px);
		py = clamp32(py);
		if (st == STAT_OK && sat) st = STAT_SAT;
		body_px = px; body_py = py; body_vx = vx; body_vy = vy;
		body_steps = body_steps + 1;
		res.radius = r[31:0];
		res.vel_x = vx[31:0];
		res.vel_y = vy[31:0];
		res.pos_x = px[31:0];
		res.pos_y = py[31:0];
		res.step_index = body_steps;
		res.status = st;
		return res;
	endfunction

	// clock and watchdog
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("central_force_orbit_step_tb failed");
		$finish;
	end

	task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fails++;
		end
	endtask

	task automatic check_result(logic [OUT_W-1:0] d);
		orbit_res_t want;
		if (orbit_queue.size() == 0) begin
			$error("result item with nothing expected: %h", d);
			fails++;
		end else begin
			want = orbit_queue.pop_front();
			field_check("radius", want.radius, d[31:0]);
			field_check("vel_x", want.vel_x, d[63:32]);
			field_check("vel_y", want.vel_y, d[95:64]);
			field_check("pos_x", want.pos_x, d[127:96]);
			field_check("pos_y", want.pos_y, d[159:128]);
			field_check("step_index", want.step_index, d[191:160]);
			field_check("status", 32'(want.status), 32'(d[193:192]));
		end
	endtask

	// output side: random stalls plus one long hold-off to back the block up
	initial begin
		int hold;
		int got;
		bit long_done;
		hold = 0;
		got = 0;
		long_done = 0;
		m_axis_tready <= 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				check_result(m_axis_tdata);
				got++;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 0;
			end else if (!long_done && got == 40) begin
				long_done = 1;
				hold = LONG_HOLD;
				m_axis_tready <= 0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 18);
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	task automatic send_item(bit reload, bit typed, logic [31:0] t_radius,
			logic [31:0] t_step, status_t t_status);
		int gap;
		orbit_res_t want;
		if (cfg_we) begin
			cfg_we <= 0;
			@(posedge clk);
		end
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= IN_W'(reload);
		do @(posedge clk); while (!s_axis_tready);
		want = advance_orbit(reload);
		if (typed) begin
			want.radius = t_radius;
			want.step_index = t_step;
			want.status = t_status;
		end
		orbit_queue.push_back(want);
	endtask

	// registers only change with the block drained
	task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
		if (s_axis_tvalid) s_axis_tvalid <= 0;
		while (orbit_queue.size() != 0) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		set_reg(idx, d);
	endtask

	function automatic logic [31:0] pick_wild();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] near_orbit(int span);
		return 32'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic random_phase();
		bit wild;
		wild = $urandom_range(0, 4) >= 3;
		if (wild) begin
			write_reg(REG_DT, pick_wild());
			write_reg(REG_EXP, $urandom());
			write_reg(REG_STR, pick_wild());
			write_reg(REG_PX, pick_wild());
			write_reg(REG_PY, pick_wild());
			write_reg(REG_VX, pick_wild());
			write_reg(REG_VY, pick_wild());
		end else begin
			write_reg(REG_DT, $urandom_range(1000, 400000));
			write_reg(REG_EXP, $urandom_range(16, 64));
			write_reg(REG_STR, 32'(RST_STR) + $urandom_range(0, 1 << 26) - (1 << 25));
			write_reg(REG_PX, near_orbit(4 << 24));
			write_reg(REG_PY, near_orbit(4 << 24));
			write_reg(REG_VX, near_orbit(8 << 24));
			write_reg(REG_VY, near_orbit(8 << 24));
		end
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_item(i == 0 ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 24) == 0),
				0, 0, 0, STAT_OK);
	endtask

	// stimulus
	initial begin
		fails = 0;
		quiet = 0;
		arst_n <= 0;
		cfg_we <= 0;
		cfg_index <= REG_DT;
		cfg_data <= 0;
		s_axis_tvalid <= 0;
		s_axis_tdata <= 0;
		root_tab[0] = 64'd1 << 30;
		root_tab[1] = floor_sqrt(64'd2 << 60);
		for (int j = 2; j <= FRAC_W; j++) root_tab[j] = floor_sqrt(root_tab[j-1] << 30);
		reg_dt = RST_DT;
		reg_exp = RST_EXP;
		reg_str = RST_STR;
		start_px = longint'($signed(RST_PX));
		start_py = longint'($signed(RST_PY));
		start_vx = longint'($signed(RST_VX));
		start_vy = longint'($signed(RST_VY));
		body_px = start_px;
		body_py = start_py;
		body_vx = start_vx;
		body_vy = start_vy;
		body_steps = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_reg(script[i].idx, script[i].data);
			else
				send_item(script[i].reload, script[i].typed, script[i].t_radius,
					script[i].t_step, script[i].t_status);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == QUIET_PHASE) quiet = 1;
			random_phase();
		end
		s_axis_tvalid <= 0;

		while (orbit_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("central_force_orbit_step_tb passed");
		else
			$display("central_force_orbit_step_tb failed");
		$finish;
	end

endmodule

>>> sim.f
src/cfos_pkg.sv
src/central_force_orbit_step.sv
tb/central_force_orbit_step_tb.sv
